### rtl/gltt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gltt_pkg
// Shared types, codes and helpers for the gate list truth table engine.
// ----------------------------------------------------------------------------
package gltt_pkg;

	localparam int MAX_INPUTS       = 6;
	localparam int MAX_OUTPUTS      = 16;
	localparam int MAX_GATES_DEF    = 64;

	localparam int CMD_W      = 2;
	localparam int KIND_W     = 3;
	localparam int VAR_IDX_W  = 6;
	localparam int IC_W       = 3;
	localparam int OC_W       = 5;
	localparam int ROW_W      = 6;
	localparam int OBITS_W    = 16;
	localparam int OUT_IDX_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_RUN    = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NOT  = 3'd0,
		KIND_AND  = 3'd1,
		KIND_OR   = 3'd2,
		KIND_NOR  = 3'd3,
		KIND_NAND = 3'd4,
		KIND_XOR  = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_COUNT  = 1'b0,
		CFG_OUTPUT_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_IN,
		ST_GFETCH,
		ST_GREAD,
		ST_GEXEC,
		ST_ORD,
		ST_OCAP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [VAR_IDX_W-1:0] src_a;
		logic [VAR_IDX_W-1:0] src_b;
		logic [VAR_IDX_W-1:0] target;
	} gate_t;

	// returns {write enable, result bit}
	function automatic logic [1:0] gate_eval(logic [KIND_W-1:0] kind, logic a, logic b);
		logic [1:0] res;
		case (kind)
			KIND_NOT:  res = {1'b1, ~a};
			KIND_AND:  res = {1'b1, a & b};
			KIND_OR:   res = {1'b1, a | b};
			KIND_NOR:  res = {1'b1, ~(a | b)};
			KIND_NAND: res = {1'b1, ~(a & b)};
			KIND_XOR:  res = {1'b1, a ^ b};
			default:   res = 2'b00;
		endcase
		return res;
	endfunction

endpackage

### rtl/gate_list_truth_table_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_list_truth_table_engine_unit
// Gate list evaluator that sweeps every input combination of a loaded netlist.
//
// Commands arrive as beats on the s_ group, the command in s_tuser: append a
// gate, clear the list and variable store, or run. Append and clear give no
// output beat.
// A run gives one m_ beat per row, 2**n rows, with m_tlast on the last one.
// A row runs these steps (n inputs, G gates, m outputs): the
// inputs are written one per cycle, each gate takes a program read, a store
// read and a store write on the single-bit store, and each output bit takes
// one store read and a capture. s_tready is high only while no run is in
// progress. Results leave through one output register; when the receiver
// stalls, the next row is computed and then held until the register is free.
// Reset clears the gate count, the store valid bits (all variables read 0),
// the output register and sets both count registers to 1; no sweep is needed.
// Configuration is written through cfg_we / cfg_index / cfg_data by the user
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gate_list_truth_table_engine_unit
	import gltt_pkg::*;
#(
	parameter int MAX_GATES = MAX_GATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// gate_kind[2:0], source_a[8:3], source_b[14:9], target[20:15]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [CMD_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// row_index[5:0], output_bits[21:6]
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tlast
);

	localparam int GCNT_W = $clog2(MAX_GATES + 1);
	localparam int GADR_W = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int NVARS  = 2 ** VAR_IDX_W;

	state_t state_q, state_d;

	logic [IC_W-1:0]      cfg_ic_q;
	logic [OC_W-1:0]      cfg_oc_q;
	logic [IC_W-1:0]      n_q;
	logic [OC_W-1:0]      m_q;
	logic [ROW_W-1:0]     r_q;
	logic [IC_W-1:0]      i_q;
	logic [OUT_IDX_W-1:0] j_q;
	logic [GCNT_W-1:0]    k_q;
	logic [GCNT_W-1:0]    gcnt_q;
	logic [OBITS_W-1:0]   bits_q;

	gate_t prog_mem [MAX_GATES];
	gate_t prog_rd_q;

	logic var_mem [NVARS];
	logic [NVARS-1:0] var_vld_q;
	logic rda_q, rdb_q;

	logic                 out_vld_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [OBITS_W-1:0]   out_bits_q;
	logic                 out_last_q;

	logic [CMD_W-1:0]     in_cmd;
	gate_t                in_gate;
	logic                 acc;
	logic                 in_last, k_last, j_last, row_last_hit, out_free;
	logic [ROW_W-1:0]     row_last;
	logic [IC_W-1:0]      in_sh;
	logic [1:0]           ge;
	logic [IC_W-1:0]      n_sat;
	logic [OC_W-1:0]      m_sat;

	logic                 var_we;
	logic [VAR_IDX_W-1:0] var_wa;
	logic                 var_wd;
	logic [VAR_IDX_W-1:0] rd_a_addr, rd_b_addr;
	logic                 emit_load;

	assign in_cmd  = s_tuser;
	assign in_gate = '{kind:   s_tdata[2:0],
	                   src_a:  s_tdata[8:3],
	                   src_b:  s_tdata[14:9],
	                   target: s_tdata[20:15]};

	assign n_sat = (cfg_ic_q == '0) ? IC_W'(1) :
	               (cfg_ic_q > IC_W'(MAX_INPUTS)) ? IC_W'(MAX_INPUTS) : cfg_ic_q;
	assign m_sat = (cfg_oc_q == '0) ? OC_W'(1) :
	               (cfg_oc_q > OC_W'(MAX_OUTPUTS)) ? OC_W'(MAX_OUTPUTS) : cfg_oc_q;

	assign in_last      = (i_q + IC_W'(1) == n_q);
	assign k_last       = (k_q + GCNT_W'(1) == gcnt_q);
	assign j_last       = (OC_W'(j_q) + OC_W'(1) == m_q);
	assign row_last     = ROW_W'((7'd1 << n_q) - 7'd1);
	assign row_last_hit = (r_q == row_last);
	assign out_free     = !out_vld_q || m_tready;
	assign in_sh        = n_q - IC_W'(1) - i_q;
	assign ge           = gate_eval(prog_rd_q.kind, rda_q, rdb_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && in_cmd == CMD_RUN) state_d = ST_IN;
			end
			ST_IN: begin
				if (in_last) state_d = (gcnt_q == '0) ? ST_ORD : ST_GFETCH;
			end
			ST_GFETCH: state_d = ST_GREAD;
			ST_GREAD:  state_d = ST_GEXEC;
			ST_GEXEC:  state_d = k_last ? ST_ORD : ST_GFETCH;
			ST_ORD:    state_d = ST_OCAP;
			ST_OCAP:   state_d = j_last ? ST_EMIT : ST_ORD;
			ST_EMIT: begin
				if (out_free) state_d = row_last_hit ? ST_IDLE : ST_IN;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		var_we    = 1'b0;
		var_wa    = VAR_IDX_W'(i_q);
		var_wd    = r_q[0];
		rd_a_addr = prog_rd_q.src_a;
		rd_b_addr = prog_rd_q.src_b;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_IN: begin
				var_we = 1'b1;
				var_wa = VAR_IDX_W'(i_q);
				var_wd = r_q[in_sh];
			end
			ST_GEXEC: begin
				var_we = ge[1];
				var_wa = prog_rd_q.target;
				var_wd = ge[0];
			end
			ST_ORD:   rd_a_addr = VAR_IDX_W'(n_q) + VAR_IDX_W'(j_q);
			ST_EMIT:  emit_load = out_free;
			default: begin
			end
		endcase
	end

	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cfg_ic_q <= IC_W'(1);
			cfg_oc_q <= OC_W'(1);
			gcnt_q   <= '0;
			n_q      <= IC_W'(1);
			m_q      <= OC_W'(1);
			r_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INPUT_COUNT:  cfg_ic_q <= cfg_data[IC_W-1:0];
					CFG_OUTPUT_COUNT: cfg_oc_q <= cfg_data[OC_W-1:0];
					default: begin
					end
				endcase
			end
			if (acc) begin
				case (in_cmd)
					CMD_APPEND: begin
						if (gcnt_q != GCNT_W'(MAX_GATES)) gcnt_q <= gcnt_q + GCNT_W'(1);
					end
					CMD_CLEAR: gcnt_q <= '0;
					CMD_RUN: begin
						n_q <= n_sat;
						m_q <= m_sat;
						r_q <= '0;
						i_q <= '0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IN: begin
					i_q <= i_q + IC_W'(1);
					k_q <= '0;
					j_q <= '0;
				end
				ST_GEXEC: k_q <= k_q + GCNT_W'(1);
				ST_OCAP:  j_q <= j_q + OUT_IDX_W'(1);
				ST_EMIT: begin
					if (out_free) begin
						r_q <= r_q + ROW_W'(1);
						i_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// gate program memory
	always_ff @(posedge clk) begin
		if (acc && in_cmd == CMD_APPEND && gcnt_q != GCNT_W'(MAX_GATES))
			prog_mem[gcnt_q[GADR_W-1:0]] <= in_gate;
		prog_rd_q <= prog_mem[k_q[GADR_W-1:0]];
	end

	// variable store, unwritten entries read 0
	always_ff @(posedge clk) begin
		if (var_we) var_mem[var_wa] <= var_wd;
		rda_q <= var_vld_q[rd_a_addr] && var_mem[rd_a_addr];
		rdb_q <= var_vld_q[rd_b_addr] && var_mem[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q <= '0;
		end else if (acc && in_cmd == CMD_CLEAR) begin
			var_vld_q <= '0;
		end else if (var_we) begin
			var_vld_q[var_wa] <= 1'b1;
		end
	end

	// output bit gather
	always_ff @(posedge clk) begin
		if (state_q == ST_IN) bits_q <= '0;
		else if (state_q == ST_OCAP) bits_q[j_q] <= rda_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_row_q  <= r_q;
			out_bits_q <= bits_q;
			out_last_q <= row_last_hit;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(M_TDATA_W - OBITS_W - ROW_W)'(0), out_bits_q, out_row_q};
	assign m_tlast  = out_last_q;

endmodule

### sim/gate_list_truth_table_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_list_truth_table_engine_unit_tb
// Self-checking bench for the gate list truth table engine. A behavioral
// netlist evaluator predicts every truth table row from the accepted command
// beats. Directed tests cover each gate kind, unused kinds and commands, count
// saturation and the full gate list. Random netlists follow under several
// idle and stall mixes, and one test holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module gate_list_truth_table_engine_unit_tb;
	import gltt_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 3000;

	typedef struct packed {
		logic [VAR_IDX_W-1:0] target;
		logic [VAR_IDX_W-1:0] src_b;
		logic [VAR_IDX_W-1:0] src_a;
		logic [KIND_W-1:0]    kind;
		logic [CMD_W-1:0]     cmd;
	} cmd_beat_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [OBITS_W-1:0] bits;
		logic               is_last;
	} truth_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// gate_kind[2:0], source_a[8:3], source_b[14:9], target[20:15]
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	// cmd[1:0]
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// row_index[5:0], output_bits[21:6]
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;

	gate_t            netlist [MAX_GATES_DEF];
	int               gates_loaded = 0;
	logic [63:0]      var_bits = '0;
	logic [IC_W-1:0]  in_count_reg = 3'd1;
	logic [OC_W-1:0]  out_count_reg = 5'd1;
	truth_row_t       pending_rows [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_id = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int mismatches = 0;

	gate_list_truth_table_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_inputs();
		if (in_count_reg == 0) return 1;
		if (in_count_reg > MAX_INPUTS) return MAX_INPUTS;
		return int'(in_count_reg);
	endfunction

	function automatic int eff_outputs();
		if (out_count_reg == 0) return 1;
		if (out_count_reg > MAX_OUTPUTS) return MAX_OUTPUTS;
		return int'(out_count_reg);
	endfunction

	// Update the netlist state for one beat and queue the rows it yields.
	function automatic void apply_command(input cmd_beat_t b);
		int n;
		int m;
		int rows;
		int r;
		int i;
		int j;
		int k;
		gate_t g;
		logic a;
		logic c;
		logic [OBITS_W-1:0] outs;
		if (b.cmd == CMD_APPEND) begin
			if (gates_loaded < MAX_GATES_DEF) begin
				netlist[gates_loaded] = '{kind: b.kind, src_a: b.src_a,
					src_b: b.src_b, target: b.target};
				gates_loaded++;
			end
		end else if (b.cmd == CMD_CLEAR) begin
			gates_loaded = 0;
			var_bits = '0;
		end else if (b.cmd == CMD_RUN) begin
			n = eff_inputs();
			m = eff_outputs();
			rows = 1 << n;
			for (r = 0; r < rows; r++) begin
				for (i = 0; i < n; i++)
					var_bits[i] = r[n - 1 - i];
				for (k = 0; k < gates_loaded; k++) begin
					g = netlist[k];
					a = var_bits[g.src_a];
					c = var_bits[g.src_b];
					case (g.kind)
						KIND_NOT:  var_bits[g.target] = ~a;
						KIND_AND:  var_bits[g.target] = a & c;
						KIND_OR:   var_bits[g.target] = a | c;
						KIND_NOR:  var_bits[g.target] = ~(a | c);
						KIND_NAND: var_bits[g.target] = ~(a & c);
						KIND_XOR:  var_bits[g.target] = a ^ c;
						default: ;
					endcase
				end
				outs = '0;
				for (j = 0; j < m; j++)
					outs[j] = var_bits[n + j];
				pending_rows.push_back('{row: ROW_W'(r), bits: outs,
					is_last: (r == rows - 1)});
			end
		end
	endfunction

	function automatic cmd_beat_t mk_gate(input logic [KIND_W-1:0] kind,
		input logic [VAR_IDX_W-1:0] a, input logic [VAR_IDX_W-1:0] b,
		input logic [VAR_IDX_W-1:0] t);
		cmd_beat_t beat;
		beat.cmd = CMD_APPEND;
		beat.kind = kind;
		beat.src_a = a;
		beat.src_b = b;
		beat.target = t;
		return beat;
	endfunction

	// Control beats carry random filler in the gate fields.
	function automatic cmd_beat_t mk_ctl(input logic [CMD_W-1:0] cmd);
		cmd_beat_t beat;
		beat.cmd = cmd;
		beat.kind = KIND_W'($urandom);
		beat.src_a = VAR_IDX_W'($urandom);
		beat.src_b = VAR_IDX_W'($urandom);
		beat.target = VAR_IDX_W'($urandom);
		return beat;
	endfunction

	// Keep operands and targets mostly among the live inputs and outputs.
	function automatic cmd_beat_t random_gate(input int n, input int m);
		cmd_beat_t beat;
		int span;
		span = n + m + 4;
		beat.cmd = CMD_APPEND;
		if ($urandom_range(9) == 0)
			beat.kind = ($urandom_range(1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
		else
			beat.kind = KIND_W'($urandom_range(5));
		beat.src_a = ($urandom_range(4) == 0) ? VAR_IDX_W'($urandom) :
			VAR_IDX_W'($urandom_range(span - 1));
		beat.src_b = ($urandom_range(4) == 0) ? VAR_IDX_W'($urandom) :
			VAR_IDX_W'($urandom_range(span - 1));
		beat.target = ($urandom_range(4) == 0) ? VAR_IDX_W'($urandom) :
			VAR_IDX_W'($urandom_range(span - 1, n));
		return beat;
	endfunction

	task automatic send_beat(input cmd_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({b.target, b.src_b, b.src_a, b.kind});
		s_tuser <= b.cmd;
		do @(posedge clk); while (!s_tready);
		apply_command(b);
	endtask

	// Drop valid and wait until every predicted row has been seen.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INPUT_COUNT)
			in_count_reg = val[IC_W-1:0];
		else
			out_count_reg = val[OC_W-1:0];
		@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_beat(mk_ctl(CMD_RUN));
		send_beat(mk_ctl(CMD_CLEAR));
		send_beat(mk_ctl(CMD_UNUSED));
		send_beat(mk_ctl(CMD_RUN));
		settle();
	endtask

	task automatic test_gate_kinds();
		write_reg(CFG_INPUT_COUNT, 5'd2);
		write_reg(CFG_OUTPUT_COUNT, 5'd8);
		send_beat(mk_gate(KIND_NOT, 6'd0, 6'd1, 6'd2));
		send_beat(mk_gate(KIND_AND, 6'd0, 6'd1, 6'd3));
		send_beat(mk_gate(KIND_OR, 6'd0, 6'd1, 6'd4));
		send_beat(mk_gate(KIND_NOR, 6'd0, 6'd1, 6'd5));
		send_beat(mk_gate(KIND_NAND, 6'd0, 6'd1, 6'd6));
		send_beat(mk_gate(KIND_XOR, 6'd0, 6'd1, 6'd7));
		send_beat(mk_gate(KIND_SPARE_LO, 6'd0, 6'd1, 6'd2));
		send_beat(mk_gate(KIND_SPARE_HI, 6'd1, 6'd0, 6'd3));
		send_beat(mk_gate(KIND_XOR, 6'd63, 6'd63, 6'd63));
		send_beat(mk_gate(KIND_AND, 6'd63, 6'd0, 6'd8));
		send_beat(mk_gate(KIND_NOT, 6'd63, 6'd63, 6'd9));
		send_beat(mk_ctl(CMD_RUN));
		send_beat(mk_ctl(CMD_RUN));
		settle();
	endtask

	task automatic test_count_saturation();
		write_reg(CFG_INPUT_COUNT, 5'd0);
		write_reg(CFG_OUTPUT_COUNT, 5'd0);
		send_beat(mk_ctl(CMD_RUN));
		settle();
		write_reg(CFG_INPUT_COUNT, 5'd7);
		write_reg(CFG_OUTPUT_COUNT, 5'd31);
		send_beat(mk_ctl(CMD_RUN));
		settle();
	endtask

	task automatic test_full_list();
		int k;
		write_reg(CFG_INPUT_COUNT, 5'd6);
		write_reg(CFG_OUTPUT_COUNT, 5'd16);
		send_beat(mk_ctl(CMD_CLEAR));
		for (k = 0; k < MAX_GATES_DEF; k++)
			send_beat(random_gate(MAX_INPUTS, MAX_OUTPUTS));
		send_beat(mk_gate(KIND_NOT, 6'd0, 6'd0, 6'd6));
		send_beat(mk_gate(KIND_NOT, 6'd1, 6'd1, 6'd7));
		send_beat(mk_ctl(CMD_RUN));
		send_beat(mk_ctl(CMD_CLEAR));
		send_beat(mk_ctl(CMD_RUN));
		settle();
	endtask

	task automatic test_backpressure();
		int k;
		write_reg(CFG_INPUT_COUNT, 5'd5);
		write_reg(CFG_OUTPUT_COUNT, 5'd4);
		send_beat(mk_ctl(CMD_CLEAR));
		for (k = 0; k < 4; k++)
			send_beat(random_gate(5, 4));
		hold_id++;
		send_beat(mk_ctl(CMD_RUN));
		send_beat(random_gate(5, 4));
		send_beat(mk_ctl(CMD_RUN));
		settle();
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct,
		input int stall);
		int sent;
		int len;
		int k;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(3) == 0) begin
				settle();
				if ($urandom_range(9) == 0)
					write_reg(CFG_INPUT_COUNT, {2'($urandom), 3'($urandom_range(7, 5))});
				else
					write_reg(CFG_INPUT_COUNT, {2'($urandom), 3'($urandom_range(4))});
				write_reg(CFG_OUTPUT_COUNT, 5'($urandom));
			end
			if (gates_loaded > 40 || $urandom_range(3) == 0) begin
				send_beat(mk_ctl(CMD_CLEAR));
				sent++;
			end
			len = $urandom_range(10, 1);
			for (k = 0; k < len; k++) begin
				send_beat(random_gate(eff_inputs(), eff_outputs()));
				sent++;
			end
			if ($urandom_range(7) == 0)
				send_beat(mk_ctl(CMD_UNUSED));
			// leave some netlists without a run
			if ($urandom_range(9) != 0) begin
				send_beat(mk_ctl(CMD_RUN));
				sent++;
			end
		end
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_id != hold_ack) begin
			hold_ack <= hold_id;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : row_check
		truth_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row beat, expected none, got row_index %0d",
					$time, m_tdata[ROW_W-1:0]);
				mismatches++;
			end else begin
				want = pending_rows.pop_front();
				if (m_tdata[ROW_W-1:0] !== want.row) begin
					$display("%0t: row_index mismatch, expected %0d, got %0d",
						$time, want.row, m_tdata[ROW_W-1:0]);
					mismatches++;
				end
				if (m_tdata[ROW_W +: OBITS_W] !== want.bits) begin
					$display("%0t: output_bits mismatch, expected %h, got %h",
						$time, want.bits, m_tdata[ROW_W +: OBITS_W]);
					mismatches++;
				end
				if (m_tlast !== want.is_last) begin
					$display("%0t: last_row mismatch, expected %b, got %b",
						$time, want.is_last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_gate_kinds();
		test_count_saturation();
		test_full_list();
		test_backpressure();
		test_random_traffic(8, 0, 0);
		test_random_traffic(8, 50, 0);
		test_random_traffic(8, 0, 50);
		test_random_traffic(8, 23, 23);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule

### gate_list_truth_table_engine_unit.f
rtl/gltt_pkg.sv
rtl/gate_list_truth_table_engine_unit.sv
sim/gate_list_truth_table_engine_unit_tb.sv
